### src/isr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// isr_pkg - shared types for the Ising ring spin update block
// Item kinds, register indexes, controller states and the command/status
// bundles that join the controller and the datapath.
// ============================================================================
package isr_pkg;

    localparam int KIND_W  = 2;
    localparam int SITE_W  = 10;
    localparam int RAND_W  = 32;
    localparam int THR_W   = 33;
    localparam int SUM_W   = 12;
    localparam int CNT_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 96;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD    = 2'd0,
        KIND_TRIAL   = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE            = 3'd0,
        CFG_RING_SIZE       = 3'd1,
        CFG_THR_UP_MINUS2   = 3'd2,
        CFG_THR_UP_ZERO     = 3'd3,
        CFG_THR_UP_PLUS2    = 3'd4,
        CFG_THR_DOWN_MINUS2 = 3'd5,
        CFG_THR_DOWN_ZERO   = 3'd6,
        CFG_THR_DOWN_PLUS2  = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_L,
        ST_RD_R,
        ST_RD_S,
        ST_EVAL,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RD_LEFT,
        RD_RIGHT,
        RD_SITE
    } rd_sel_t;

    typedef struct packed {
        logic    load_item;
        rd_sel_t rd_sel;
        logic    cap_l;
        logic    cap_r;
        logic    cap_c;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        logic clearing;
        logic needs_ring;
        logic out_free;
    } stat_t;

endpackage

### src/isr_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// isr_ctrl - sequencer for the spin update
// Walks one item through any neighbor and site reads and the final update.
// ============================================================================
module isr_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  isr_pkg::stat_t stat,
    output isr_pkg::cmd_t  cmd
);

    isr_pkg::state_t state_reg;
    isr_pkg::state_t state_next;
    logic            accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = stat.needs_ring ? isr_pkg::ST_RD_L : isr_pkg::ST_FINISH;
                end
            end
            isr_pkg::ST_RD_L:   state_next = isr_pkg::ST_RD_R;
            isr_pkg::ST_RD_R:   state_next = isr_pkg::ST_RD_S;
            isr_pkg::ST_RD_S:   state_next = isr_pkg::ST_EVAL;
            isr_pkg::ST_EVAL:   state_next = isr_pkg::ST_FINISH;
            isr_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = isr_pkg::ST_IDLE;
                end
            end
            default:            state_next = isr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.rd_sel    = isr_pkg::RD_SITE;
        case (state_reg)
            isr_pkg::ST_IDLE:
            begin
                in_ready      = !stat.clearing;
                cmd.load_item = in_valid && !stat.clearing;
            end
            isr_pkg::ST_RD_L:
            begin
                cmd.rd_sel = isr_pkg::RD_LEFT;
            end
            isr_pkg::ST_RD_R:
            begin
                cmd.rd_sel = isr_pkg::RD_RIGHT;
                cmd.cap_l  = 1'b1;
            end
            isr_pkg::ST_RD_S:
            begin
                cmd.rd_sel = isr_pkg::RD_SITE;
                cmd.cap_r  = 1'b1;
            end
            isr_pkg::ST_EVAL:
            begin
                cmd.cap_c = 1'b1;
            end
            isr_pkg::ST_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### src/isr_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// isr_datapath - spin memory, sums, counters and threshold compare
// Holds the ring in a one-bit memory with a clearing sweep, the config
// registers, the incremental sums and the result register.
// ============================================================================
module isr_datapath
#(
    parameter int MAX_SPINS = 1024
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [isr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [isr_pkg::THR_W-1:0]       cfg_data,
    input  logic [isr_pkg::KIND_W-1:0]      in_kind,
    input  logic [isr_pkg::SITE_W-1:0]      in_site,
    input  logic                            in_spin_value,
    input  logic [isr_pkg::RAND_W-1:0]      in_random_word,
    input  isr_pkg::cmd_t                   cmd,
    output isr_pkg::stat_t                  stat,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic                            out_status,
    output logic                            out_spin_after,
    output logic                            out_flipped,
    output logic [isr_pkg::SUM_W-1:0]       out_bond_total,
    output logic [isr_pkg::SUM_W-1:0]       out_magnetization,
    output logic [isr_pkg::CNT_W-1:0]       out_accepted_total,
    output logic [isr_pkg::CNT_W-1:0]       out_attempted_total
);

    localparam int AW    = (MAX_SPINS > 1) ? $clog2(MAX_SPINS) : 1;
    localparam int SW    = $clog2(MAX_SPINS + 1);
    localparam int N_RST = (MAX_SPINS < 64) ? MAX_SPINS : 64;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SPINS - 1);
    localparam logic [isr_pkg::SUM_W-1:0] SUM_RST = isr_pkg::SUM_W'(N_RST);
    localparam logic [isr_pkg::CNT_W-1:0] CNT_MAX = '1;

    // spin memory
    logic mem [MAX_SPINS];
    logic rd_q_reg;
    logic mem_we;
    logic [AW-1:0] mem_wa;
    logic mem_wd;
    logic [AW-1:0] mem_ra;

    // config
    logic                      mode_reg;
    logic [SW-1:0]             n_reg;
    logic [isr_pkg::THR_W-1:0] thr_reg [6];

    // clearing sweep
    logic          clearing_reg;
    logic          clearing_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    // running state
    logic [isr_pkg::SUM_W-1:0] bond_reg, bond_next;
    logic [isr_pkg::SUM_W-1:0] mag_reg, mag_next;
    logic [isr_pkg::CNT_W-1:0] acc_reg, acc_next;
    logic [isr_pkg::CNT_W-1:0] att_reg, att_next;

    // current item
    isr_pkg::kind_t              kind_reg;
    logic [isr_pkg::SITE_W-1:0]  site_reg;
    logic                        spin_val_reg;
    logic [isr_pkg::RAND_W-1:0]  rw_reg;
    logic                        in_range_reg;
    logic                        sl_reg, sr_reg, sc_reg;

    // result
    logic ov_reg, ov_next;
    logic ostat_reg, ostat_next;
    logic ospin_reg, ospin_next;
    logic oflip_reg, oflip_next;

    logic          in_range;
    logic [AW-1:0] site_a;
    logic [AW-1:0] n_m1;
    logic [AW-1:0] left_a;
    logic [AW-1:0] right_a;
    logic [31:0]   rs_w;
    logic [31:0]   n_new;
    logic [1:0]    sel;
    logic [2:0]    thr_idx;
    logic          hit;
    logic          metro;
    logic          newv;
    logic          flip;
    logic [isr_pkg::SUM_W-1:0] dmag;
    logic [isr_pkg::SUM_W-1:0] dbond;

    assign in_range = {22'd0, in_site} < 32'(n_reg);

    assign site_a  = AW'(site_reg);
    assign n_m1    = AW'(n_reg - SW'(1));
    assign left_a  = (site_a == '0) ? n_m1 : site_a - AW'(1);
    assign right_a = (site_a == n_m1) ? '0 : site_a + AW'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            isr_pkg::RD_LEFT:  mem_ra = left_a;
            isr_pkg::RD_RIGHT: mem_ra = right_a;
            default:           mem_ra = site_a;
        endcase
    end

    // threshold choice: spin +1 or Gibbs uses the "up" row
    assign sel     = {1'b0, sl_reg} + {1'b0, sr_reg};
    assign thr_idx = (sc_reg || !mode_reg) ? {1'b0, sel} : 3'd3 + {1'b0, sel};
    assign hit     = {1'b0, rw_reg} < thr_reg[thr_idx];
    assign metro   = (kind_reg == isr_pkg::KIND_TRIAL) && mode_reg;

    always_comb
    begin
        if (kind_reg == isr_pkg::KIND_LOAD)
        begin
            newv = spin_val_reg;
        end
        else if (metro)
        begin
            newv = hit ? !sc_reg : sc_reg;
        end
        else
        begin
            newv = hit;
        end
    end

    assign flip  = newv != sc_reg;
    assign dmag  = newv ? isr_pkg::SUM_W'(2) : -isr_pkg::SUM_W'(2);
    assign dbond = (sel == 2'd1) ? '0 :
                   ((newv == sel[1]) ? isr_pkg::SUM_W'(4) : -isr_pkg::SUM_W'(4));

    assign rs_w  = {21'd0, cfg_data[10:0]};
    assign n_new = (rs_w < 32'd3) ? 32'd3 :
                   ((rs_w > 32'(MAX_SPINS)) ? 32'(MAX_SPINS) : rs_w);

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        bond_next     = bond_reg;
        mag_next      = mag_reg;
        acc_next      = acc_reg;
        att_next      = att_reg;
        ov_next       = ov_reg && !out_ready;
        ostat_next    = ostat_reg;
        ospin_next    = ospin_reg;
        oflip_next    = oflip_reg;
        mem_we        = 1'b0;
        mem_wa        = site_a;
        mem_wd        = newv;

        if (clearing_reg)
        begin
            mem_we        = 1'b1;
            mem_wa        = clr_addr_reg;
            mem_wd        = 1'b1;
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
        end

        if (cmd.finish)
        begin
            ov_next    = 1'b1;
            ostat_next = 1'b0;
            ospin_next = 1'b0;
            oflip_next = 1'b0;
            case (kind_reg)
                isr_pkg::KIND_RESTART:
                begin
                    bond_next     = isr_pkg::SUM_W'(n_reg);
                    mag_next      = isr_pkg::SUM_W'(n_reg);
                    clearing_next = 1'b1;
                    clr_addr_next = '0;
                end
                isr_pkg::KIND_CLEAR:
                begin
                    acc_next = '0;
                    att_next = '0;
                end
                default:
                begin
                    if (!in_range_reg)
                    begin
                        ostat_next = 1'b1;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        ospin_next = newv;
                        oflip_next = flip;
                        if (flip)
                        begin
                            mag_next  = mag_reg + dmag;
                            bond_next = bond_reg + dbond;
                        end
                        if (metro)
                        begin
                            if (att_reg != CNT_MAX)
                            begin
                                att_next = att_reg + isr_pkg::CNT_W'(1);
                            end
                            if (hit && acc_reg != CNT_MAX)
                            begin
                                acc_next = acc_reg + isr_pkg::CNT_W'(1);
                            end
                        end
                    end
                end
            endcase
        end

        // ring size write restarts the ring
        if (cfg_we && isr_pkg::cfg_idx_t'(cfg_index) == isr_pkg::CFG_RING_SIZE)
        begin
            bond_next     = isr_pkg::SUM_W'(n_new);
            mag_next      = isr_pkg::SUM_W'(n_new);
            clearing_next = 1'b1;
            clr_addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b1;
            n_reg        <= SW'(N_RST);
            for (int i = 0; i < 6; i++)
            begin
                thr_reg[i] <= {1'b1, 32'd0};
            end
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            bond_reg     <= SUM_RST;
            mag_reg      <= SUM_RST;
            acc_reg      <= '0;
            att_reg      <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            bond_reg     <= bond_next;
            mag_reg      <= mag_next;
            acc_reg      <= acc_next;
            att_reg      <= att_next;
            ov_reg       <= ov_next;
            if (cfg_we)
            begin
                case (isr_pkg::cfg_idx_t'(cfg_index))
                    isr_pkg::CFG_MODE:            mode_reg   <= cfg_data[0];
                    isr_pkg::CFG_RING_SIZE:       n_reg      <= SW'(n_new);
                    isr_pkg::CFG_THR_UP_MINUS2:   thr_reg[0] <= cfg_data;
                    isr_pkg::CFG_THR_UP_ZERO:     thr_reg[1] <= cfg_data;
                    isr_pkg::CFG_THR_UP_PLUS2:    thr_reg[2] <= cfg_data;
                    isr_pkg::CFG_THR_DOWN_MINUS2: thr_reg[3] <= cfg_data;
                    isr_pkg::CFG_THR_DOWN_ZERO:   thr_reg[4] <= cfg_data;
                    isr_pkg::CFG_THR_DOWN_PLUS2:  thr_reg[5] <= cfg_data;
                    default:                      mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ostat_reg <= ostat_next;
        ospin_reg <= ospin_next;
        oflip_reg <= oflip_next;
        if (cmd.load_item)
        begin
            kind_reg     <= isr_pkg::kind_t'(in_kind);
            site_reg     <= in_site;
            spin_val_reg <= in_spin_value;
            rw_reg       <= in_random_word;
            in_range_reg <= in_range;
        end
        if (cmd.cap_l)
        begin
            sl_reg <= rd_q_reg;
        end
        if (cmd.cap_r)
        begin
            sr_reg <= rd_q_reg;
        end
        if (cmd.cap_c)
        begin
            sc_reg <= rd_q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_q_reg <= mem[mem_ra];
    end

    assign stat.clearing   = clearing_reg;
    assign stat.needs_ring = in_range &&
                             (isr_pkg::kind_t'(in_kind) == isr_pkg::KIND_LOAD ||
                              isr_pkg::kind_t'(in_kind) == isr_pkg::KIND_TRIAL);
    assign stat.out_free   = !ov_reg || out_ready;

    assign out_valid           = ov_reg;
    assign out_status          = ostat_reg;
    assign out_spin_after      = ospin_reg;
    assign out_flipped         = oflip_reg;
    assign out_bond_total      = bond_reg;
    assign out_magnetization   = mag_reg;
    assign out_accepted_total  = acc_reg;
    assign out_attempted_total = att_reg;

endmodule

### src/ising_ring_spin_update_top.sv
`timescale 1ns / 1ps
// ============================================================================
// ising_ring_spin_update_top - Monte Carlo spin update on a periodic ring
// Metropolis or Gibbs update of one site per trial beat, with incremental
// bond sum, magnetization and acceptance counters.
// ============================================================================
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        tuser kind, tdata site/spin/random
//  m_axis    out        tvalid / tready        tdata status .. attempted_total
//  cfg       in         cfg_we (no wait)       cfg_index, cfg_data
//
//  Load or trial beat with site in the ring: the controller steps through
//  left, right and site reads (they share the single read port of the spin
//  memory), an evaluate step and the final update.
//  Restart, clear-counters and out-of-ring beats go from accept straight to
//  the final update. The next beat is accepted only after that update.
//  A clearing sweep of all MAX_SPINS spins runs after reset, after a restart
//  beat and after a ring_size write; s_axis_tready stays low during it.
//  A stalled result holds in the output register; the next beat waits for it
//  only at its final update step.
//
module ising_ring_spin_update_top
#(
    parameter int MAX_SPINS = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [isr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [isr_pkg::THR_W-1:0]     cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // site[9:0], spin_value[10], random_word[42:11], zero fill
    input  logic [isr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // kind[1:0]
    input  logic [isr_pkg::KIND_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status[0], spin_after[1], flipped[2], bond_total[14:3],
    // magnetization[26:15], accepted_total[58:27], attempted_total[90:59], zero fill
    output logic [isr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    isr_pkg::cmd_t  cmd;
    isr_pkg::stat_t stat;

    logic                      o_status;
    logic                      o_spin;
    logic                      o_flip;
    logic [isr_pkg::SUM_W-1:0] o_bond;
    logic [isr_pkg::SUM_W-1:0] o_mag;
    logic [isr_pkg::CNT_W-1:0] o_acc;
    logic [isr_pkg::CNT_W-1:0] o_att;

    isr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    isr_datapath
    #(
        .MAX_SPINS (MAX_SPINS)
    )
    u_dp
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_kind             (s_axis_tuser),
        .in_site             (s_axis_tdata[9:0]),
        .in_spin_value       (s_axis_tdata[10]),
        .in_random_word      (s_axis_tdata[42:11]),
        .cmd                 (cmd),
        .stat                (stat),
        .out_ready           (m_axis_tready),
        .out_valid           (m_axis_tvalid),
        .out_status          (o_status),
        .out_spin_after      (o_spin),
        .out_flipped         (o_flip),
        .out_bond_total      (o_bond),
        .out_magnetization   (o_mag),
        .out_accepted_total  (o_acc),
        .out_attempted_total (o_att)
    );

    assign m_axis_tdata = {5'd0, o_att, o_acc, o_mag, o_bond, o_flip, o_spin, o_status};

endmodule

### src/isr_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// isr_checker - port-level checks for the spin update block
// Watches the stream ports of the top level; attached by bind.
// ============================================================================
module isr_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [isr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // one beat at a time: ready drops right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // out-of-ring result reports no spin and no flip
    a_bad_site: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2:1] == 2'b00)
        else $error("out-of-ring result carries spin or flip");

    // accepted flips never exceed attempts
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[58:27] <= m_axis_tdata[90:59])
        else $error("accepted count above attempted count");

endmodule

bind ising_ring_spin_update_top isr_checker u_isr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/tb_ising_ring_spin_update_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_ising_ring_spin_update_top - self-checking bench for the spin ring update
// Drives load, trial, restart and clear beats in random bursts, predicts each
// result from a local copy of the ring, sums, counters and thresholds, and
// compares every result beat field by field under random output stalls.
// Phases change mode, ring size and thresholds between idle points.
// ============================================================================
module tb_ising_ring_spin_update_top;

    localparam int MAX_SPINS = 1024;
    localparam logic [isr_pkg::THR_W-1:0] THR_ONE = 33'h1_0000_0000;
    localparam logic [isr_pkg::THR_W-1:0] THR_TOP = 33'h1_FFFF_FFFF;

    typedef struct {
        isr_pkg::kind_t                 kind;
        logic [isr_pkg::SITE_W-1:0]     site;
        logic                           spin;
        logic [isr_pkg::RAND_W-1:0]     rword;
    } mc_item_t;

    typedef struct {
        logic                           status;
        logic                           spin_after;
        logic                           flipped;
        logic [isr_pkg::SUM_W-1:0]      bond;
        logic [isr_pkg::SUM_W-1:0]      magnet;
        logic [isr_pkg::CNT_W-1:0]      accepted;
        logic [isr_pkg::CNT_W-1:0]      attempted;
    } mc_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_we = 1'b0;
    logic [isr_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [isr_pkg::THR_W-1:0]          cfg_data = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [isr_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;
    logic [isr_pkg::KIND_W-1:0]         s_axis_tuser = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [isr_pkg::OUT_DATA_W-1:0]     m_axis_tdata;

    // local copy of the block state and registers
    logic [MAX_SPINS-1:0]               spin_ring;
    logic [isr_pkg::SUM_W-1:0]          bond_acc;
    logic [isr_pkg::SUM_W-1:0]          magnet_acc;
    logic [isr_pkg::CNT_W-1:0]          accept_cnt;
    logic [isr_pkg::CNT_W-1:0]          attempt_cnt;
    logic                               mode_reg;
    logic [10:0]                        ring_reg;
    logic [isr_pkg::THR_W-1:0]          thr_up [3];
    logic [isr_pkg::THR_W-1:0]          thr_dn [3];

    mc_item_t               beat_q[$];
    mc_result_t             result_q[$];
    mc_item_t               cur_beat;
    mc_result_t             mon_want;
    int                     err_count = 0;
    int                     burst_left = 0;
    int                     gap_left = 0;
    int                     run_left = 0;
    int                     stall_left = 0;

    ising_ring_spin_update_top #(.MAX_SPINS(MAX_SPINS)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned ring_len();
        if (ring_reg < 3)
            return 3;
        if (ring_reg > MAX_SPINS)
            return MAX_SPINS;
        return ring_reg;
    endfunction

    function automatic void ring_restart();
        spin_ring  = '1;
        bond_acc   = isr_pkg::SUM_W'(ring_len());
        magnet_acc = isr_pkg::SUM_W'(ring_len());
    endfunction

    // set one spin and move the sums by its change; return 1 when it changed
    function automatic logic spin_apply(int unsigned idx, logic newv, int nsum);
        int v;
        if (spin_ring[idx] == newv)
            return 1'b0;
        v = newv ? 1 : -1;
        magnet_acc = magnet_acc + isr_pkg::SUM_W'(2 * v);
        bond_acc   = bond_acc + isr_pkg::SUM_W'(2 * v * nsum);
        spin_ring[idx] = newv;
        return 1'b1;
    endfunction

    function automatic mc_result_t predict_step(mc_item_t it);
        mc_result_t                 r;
        int unsigned                n;
        int unsigned                lft;
        int unsigned                rgt;
        int                         nsum;
        int                         sel;
        logic [isr_pkg::THR_W-1:0]  thr;
        logic                       cur_s;
        n = ring_len();
        r.status     = 1'b0;
        r.spin_after = 1'b0;
        r.flipped    = 1'b0;
        if (it.kind == isr_pkg::KIND_RESTART)
            ring_restart();
        else if (it.kind == isr_pkg::KIND_CLEAR)
        begin
            accept_cnt  = '0;
            attempt_cnt = '0;
        end
        else if (it.site >= n)
            r.status = 1'b1;
        else
        begin
            lft   = (it.site == 0) ? n - 1 : it.site - 1;
            rgt   = (it.site + 1 == n) ? 0 : it.site + 1;
            nsum  = (spin_ring[lft] ? 1 : -1) + (spin_ring[rgt] ? 1 : -1);
            sel   = (nsum + 2) / 2;
            cur_s = spin_ring[it.site];
            if (it.kind == isr_pkg::KIND_LOAD)
                r.flipped = spin_apply(it.site, it.spin, nsum);
            else if (mode_reg)
            begin
                thr = cur_s ? thr_up[sel] : thr_dn[sel];
                if (attempt_cnt != '1)
                    attempt_cnt = attempt_cnt + 1;
                if ({1'b0, it.rword} < thr)
                begin
                    r.flipped = spin_apply(it.site, ~cur_s, nsum);
                    if (accept_cnt != '1)
                        accept_cnt = accept_cnt + 1;
                end
            end
            else
                r.flipped = spin_apply(it.site, {1'b0, it.rword} < thr_up[sel], nsum);
            r.spin_after = spin_ring[it.site];
        end
        r.bond      = bond_acc;
        r.magnet    = magnet_acc;
        r.accepted  = accept_cnt;
        r.attempted = attempt_cnt;
        return r;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic queue_beat(isr_pkg::kind_t k, int unsigned site, logic sp,
                              logic [isr_pkg::RAND_W-1:0] rw);
        mc_item_t it;
        it.kind  = k;
        it.site  = isr_pkg::SITE_W'(site);
        it.spin  = sp;
        it.rword = rw;
        beat_q.push_back(it);
    endtask

    // the write lands once the block samples cfg_we; the block is idle, so update the copy then
    task automatic write_reg(isr_pkg::cfg_idx_t idx, logic [isr_pkg::THR_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            isr_pkg::CFG_MODE:            mode_reg = val[0];
            isr_pkg::CFG_RING_SIZE:
            begin
                ring_reg = val[10:0];
                ring_restart();
            end
            isr_pkg::CFG_THR_UP_MINUS2:   thr_up[0] = val;
            isr_pkg::CFG_THR_UP_ZERO:     thr_up[1] = val;
            isr_pkg::CFG_THR_UP_PLUS2:    thr_up[2] = val;
            isr_pkg::CFG_THR_DOWN_MINUS2: thr_dn[0] = val;
            isr_pkg::CFG_THR_DOWN_ZERO:   thr_dn[1] = val;
            isr_pkg::CFG_THR_DOWN_PLUS2:  thr_dn[2] = val;
            default: ;
        endcase
    endtask

    // hold until every beat is in and every result is out, then let a sweep finish
    task automatic wait_idle();
        while (beat_q.size() != 0 || s_axis_tvalid || result_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic program_phase(int p);
        logic [isr_pkg::THR_W-1:0] ring_val;
        logic [isr_pkg::THR_W-1:0] t;
        logic                      m;
        int                        k;
        case (p)
            0: begin m = 1'b0; ring_val = 33'd3;          end
            1: begin m = 1'b1; ring_val = 33'd2047;       end
            2: begin m = 1'b0; ring_val = 33'd0;          end
            3: begin m = 1'b0; ring_val = 33'd1024;       end
            4: begin m = 1'b1; ring_val = 33'h1_0000_0805; end
            5: begin m = 1'($urandom_range(0, 1)); ring_val = 33'd2; end
            default:
            begin
                m = 1'($urandom_range(0, 1));
                ring_val = isr_pkg::THR_W'($urandom_range(4, 64));
            end
        endcase
        // junk in the upper bits of the mode word must be dropped
        write_reg(isr_pkg::CFG_MODE, {32'($urandom), m});
        write_reg(isr_pkg::CFG_RING_SIZE, ring_val);
        for (k = 0; k < 6; k++)
        begin
            if (p == 1 || p == 3 || $urandom_range(0, 7) == 0)
                case ($urandom_range(0, 2))
                    0:       t = '0;
                    1:       t = THR_ONE;
                    default: t = THR_TOP;
                endcase
            else
                t = {1'b0, 32'($urandom)};
            write_reg(isr_pkg::cfg_idx_t'(isr_pkg::CFG_THR_UP_MINUS2 + k), t);
        end
    endtask

    task automatic gen_random(int count);
        int unsigned                n;
        int unsigned                site;
        int                         r;
        int                         c;
        isr_pkg::kind_t             k;
        logic [isr_pkg::THR_W-1:0]  t;
        logic [isr_pkg::RAND_W-1:0] rw;
        n = ring_len();
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            site = $urandom_range(0, n - 1);
            if (r < 60)
                k = isr_pkg::KIND_TRIAL;
            else if (r < 80)
                k = isr_pkg::KIND_LOAD;
            else if (r < 92)
            begin
                k = $urandom_range(0, 1) ? isr_pkg::KIND_TRIAL : isr_pkg::KIND_LOAD;
                site = (n < MAX_SPINS) ? $urandom_range(n, MAX_SPINS - 1)
                                       : $urandom_range(0, MAX_SPINS - 1);
            end
            else if (r < 97)
            begin
                k = isr_pkg::KIND_CLEAR;
                site = $urandom_range(0, MAX_SPINS - 1);
            end
            else
            begin
                k = isr_pkg::KIND_RESTART;
                site = $urandom_range(0, MAX_SPINS - 1);
            end
            c = $urandom_range(0, 15);
            t = $urandom_range(0, 1) ? thr_up[$urandom_range(0, 2)]
                                     : thr_dn[$urandom_range(0, 2)];
            case (c)
                0:       rw = '0;
                1:       rw = '1;
                2:       rw = t[isr_pkg::RAND_W-1:0];
                3:       rw = t[isr_pkg::RAND_W-1:0] - 1;
                default: rw = $urandom;
            endcase
            queue_beat(k, site, 1'($urandom_range(0, 1)), rw);
        end
    endtask

    // driver: bursts of beats separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                result_q.push_back(predict_step(cur_beat));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (beat_q.size() > 0)
                begin
                    cur_beat = beat_q.pop_front();
                    s_axis_tdata  <= {5'b0, cur_beat.rword, cur_beat.spin, cur_beat.site};
                    s_axis_tuser  <= cur_beat.kind;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check each result beat, stall the output on its own pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (result_q.size() == 0)
                    report_error("result beat with nothing expected");
                else
                begin
                    mon_want = result_q.pop_front();
                    if (m_axis_tdata[0] !== mon_want.status)
                        report_error($sformatf("status got %0b want %0b",
                                               m_axis_tdata[0], mon_want.status));
                    if (m_axis_tdata[1] !== mon_want.spin_after)
                        report_error($sformatf("spin_after got %0b want %0b",
                                               m_axis_tdata[1], mon_want.spin_after));
                    if (m_axis_tdata[2] !== mon_want.flipped)
                        report_error($sformatf("flipped got %0b want %0b",
                                               m_axis_tdata[2], mon_want.flipped));
                    if (m_axis_tdata[14:3] !== mon_want.bond)
                        report_error($sformatf("bond_total got %0d want %0d",
                                               $signed(m_axis_tdata[14:3]),
                                               $signed(mon_want.bond)));
                    if (m_axis_tdata[26:15] !== mon_want.magnet)
                        report_error($sformatf("magnetization got %0d want %0d",
                                               $signed(m_axis_tdata[26:15]),
                                               $signed(mon_want.magnet)));
                    if (m_axis_tdata[58:27] !== mon_want.accepted)
                        report_error($sformatf("accepted_total got %0d want %0d",
                                               m_axis_tdata[58:27], mon_want.accepted));
                    if (m_axis_tdata[90:59] !== mon_want.attempted)
                        report_error($sformatf("attempted_total got %0d want %0d",
                                               m_axis_tdata[90:59], mon_want.attempted));
                end
            end
            if (run_left > 0)
            begin
                run_left--;
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                run_left   = $urandom_range(0, 40);
                stall_left = $urandom_range(1, 9);
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int p;
        mode_reg = 1'b1;
        ring_reg = 11'd64;
        for (p = 0; p < 3; p++)
        begin
            thr_up[p] = THR_ONE;
            thr_dn[p] = THR_ONE;
        end
        ring_restart();
        accept_cnt  = '0;
        attempt_cnt = '0;

        // reset defaults: Metropolis, ring of 64, every threshold always passes
        queue_beat(isr_pkg::KIND_TRIAL, 0, 1'b0, 32'hFFFF_FFFF);
        queue_beat(isr_pkg::KIND_TRIAL, 63, 1'b1, 32'h0000_0000);
        queue_beat(isr_pkg::KIND_TRIAL, 1, 1'b0, $urandom);
        queue_beat(isr_pkg::KIND_LOAD, 5, 1'b0, 32'h0000_0000);
        queue_beat(isr_pkg::KIND_LOAD, 5, 1'b0, 32'hFFFF_FFFF);
        queue_beat(isr_pkg::KIND_LOAD, 6, 1'b1, $urandom);
        queue_beat(isr_pkg::KIND_LOAD, 4, 1'b0, $urandom);
        queue_beat(isr_pkg::KIND_TRIAL, 5, 1'b1, $urandom);
        queue_beat(isr_pkg::KIND_LOAD, 64, 1'b1, $urandom);
        queue_beat(isr_pkg::KIND_TRIAL, 1023, 1'b0, 32'h0000_0000);
        queue_beat(isr_pkg::KIND_LOAD, 1023, 1'b0, 32'hFFFF_FFFF);
        queue_beat(isr_pkg::KIND_TRIAL, 62, 1'b0, $urandom);
        queue_beat(isr_pkg::KIND_CLEAR, 1023, 1'b1, 32'hFFFF_FFFF);
        queue_beat(isr_pkg::KIND_TRIAL, 0, 1'b0, $urandom);
        queue_beat(isr_pkg::KIND_RESTART, 512, 1'b1, 32'h0000_0000);
        queue_beat(isr_pkg::KIND_TRIAL, 0, 1'b1, $urandom);
        queue_beat(isr_pkg::KIND_TRIAL, 63, 1'b0, $urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait_idle();
        for (p = 0; p < 8; p++)
        begin
            program_phase(p);
            gen_random(70);
            wait_idle();
        end
        repeat (16) @(posedge clk);

        if (err_count == 0 && result_q.size() == 0)
            $display("tb_ising_ring_spin_update_top: done, clean");
        else
            $display("tb_ising_ring_spin_update_top: done, errors");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("tb_ising_ring_spin_update_top: done, errors");
        $finish;
    end

endmodule
